@@ rtl/core/pqs_pkg.sv @@
// Shared types and constants of the product-quantization distance scorer.
package pqs_pkg;

  localparam int unsigned SubQuantizers   = 16;
  localparam int unsigned Lanes           = 4;
  localparam int unsigned Groups          = SubQuantizers / Lanes;
  localparam int unsigned CodeBits        = 8;
  localparam int unsigned WordBits        = 64;
  localparam int unsigned DistBits        = 20;
  localparam int unsigned IdBits          = 32;
  localparam int unsigned DefCodebookRows = 256;
  localparam int unsigned DefEntryBits    = 16;

  localparam logic [DistBits-1:0]      DistMax = '1;
  localparam logic signed [IdBits-1:0] PadId   = '1;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActScore = 2'd1,
    ActSwap  = 2'd2
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [7:0]          lut_row;
    logic [1:0]          lut_group;
    logic [WordBits-1:0] lut_words;
    logic [30:0]         vector_id;
    logic [WordBits-1:0] codes_low;
    logic [WordBits-1:0] codes_high;
    logic                last_of_cell;
    logic                last_valid;
  } pq_item_t;

  typedef struct packed {
    logic signed [IdBits-1:0] result_id;
    logic [DistBits-1:0]      distance;
  } pq_result_t;

  typedef struct packed {
    logic                en;
    logic                bank;
    logic [7:0]          row;
    logic [1:0]          group;
    logic [WordBits-1:0] words;
  } tbl_wr_t;

  typedef struct packed {
    logic                en;
    logic                bank;
    logic [WordBits-1:0] codes_low;
    logic [WordBits-1:0] codes_high;
  } tbl_rd_t;

endpackage

@@ rtl/core/pq_lut_distance_scorer.sv @@
// Top level of the product-quantization distance scorer.
// Usage: one transaction is taken on every rising edge with start high and busy low;
// busy is never raised, so a transaction may be presented every cycle.
// A load transaction writes four table entries of one row into the fill bank.
// A swap transaction exchanges fill and compute banks; send it at a cell boundary.
// A score transaction looks up sixteen codes in the compute bank and adds the
// entries; a padded last entry of a cell gives id -1 and the all-ones distance.
// Only score transactions give a result: result_valid_o is high for one cycle with
// result_o, which is registered after the table read, the partial sums and the final
// sum; the throughput is one transaction per cycle, set by the one read port per
// sub-quantizer memory and the two-level registered adder tree.
// Results leave in order; the receiver cannot stall them and must take each one.
// Loads and scores use different banks, so no forwarding or interlock is needed.
// Reset clears the pipeline valids and selects bank zero as fill bank; table
// contents are undefined until loaded and need no clearing.
module pq_lut_distance_scorer #(
  parameter int unsigned CodebookRows = pqs_pkg::DefCodebookRows,
  parameter int unsigned EntryBits    = pqs_pkg::DefEntryBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pqs_pkg::pq_item_t   item_i,
  output logic                busy,
  output logic                result_valid_o,
  output pqs_pkg::pq_result_t result_o
);

  localparam int unsigned PartW = EntryBits + 2;
  localparam int unsigned SumW  = EntryBits + 4;
  localparam int unsigned WideW = (SumW > pqs_pkg::DistBits) ? SumW : pqs_pkg::DistBits;

  logic               accept;
  logic               fill_q, fill_d;
  pqs_pkg::tbl_wr_t   wr;
  pqs_pkg::tbl_rd_t   rd;
  logic [pqs_pkg::SubQuantizers-1:0][EntryBits-1:0] entries;
  logic [pqs_pkg::SubQuantizers-1:0]                hits;

  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic               s1_pad_q, s2_pad_q;
  logic [30:0]        s1_id_q, s2_id_q;
  logic [pqs_pkg::Groups-1:0][PartW-1:0] part_d, part_q;
  logic [SumW-1:0]    sum;
  logic [WideW-1:0]   sum_wide;
  pqs_pkg::pq_result_t out_d, out_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    fill_d = fill_q;
    if (accept && item_i.action == pqs_pkg::ActSwap) begin
      fill_d = ~fill_q;
    end
  end

  always_comb begin
    wr.en         = accept && item_i.action == pqs_pkg::ActLoad;
    wr.bank       = fill_q;
    wr.row        = item_i.lut_row;
    wr.group      = item_i.lut_group;
    wr.words      = item_i.lut_words;
    rd.en         = accept && item_i.action == pqs_pkg::ActScore;
    rd.bank       = ~fill_q;
    rd.codes_low  = item_i.codes_low;
    rd.codes_high = item_i.codes_high;
  end

  pqs_table #(
    .CodebookRows(CodebookRows),
    .EntryBits   (EntryBits)
  ) u_table (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_i     (rd),
    .entries_o(entries),
    .hit_o    (hits)
  );

  always_comb begin
    for (int g = 0; g < pqs_pkg::Groups; g++) begin
      part_d[g] = '0;
      for (int l = 0; l < pqs_pkg::Lanes; l++) begin
        if (hits[g*pqs_pkg::Lanes+l]) begin
          part_d[g] = part_d[g] + PartW'(entries[g*pqs_pkg::Lanes+l]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < pqs_pkg::Groups; g++) begin
      sum = sum + SumW'(part_q[g]);
    end
    sum_wide = WideW'(sum);
    if (s2_pad_q) begin
      out_d.result_id = pqs_pkg::PadId;
      out_d.distance  = pqs_pkg::DistMax;
    end else begin
      out_d.result_id = {1'b0, s2_id_q};
      if (sum_wide > WideW'(pqs_pkg::DistMax)) begin
        out_d.distance = pqs_pkg::DistMax;
      end else begin
        out_d.distance = sum_wide[pqs_pkg::DistBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      s1_valid_q  <= rd.en;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd.en) begin
      s1_pad_q <= item_i.last_of_cell && !item_i.last_valid;
      s1_id_q  <= item_i.vector_id;
    end
    if (s1_valid_q) begin
      s2_pad_q <= s1_pad_q;
      s2_id_q  <= s1_id_q;
      part_q   <= part_d;
    end
    if (s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  a_score_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.action == pqs_pkg::ActScore |-> ##3 result_valid_o)
    else $error("score transaction produced no result");

  a_result_has_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(rd.en, 3))
    else $error("result without score transaction");

  a_pad_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.result_id[pqs_pkg::IdBits-1]
      |-> result_o.distance == pqs_pkg::DistMax)
    else $error("padded result without maximum distance");

  a_swap_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.action == pqs_pkg::ActSwap |=> fill_q != $past(fill_q))
    else $error("bank swap lost");

endmodule

@@ rtl/core/pqs_table.sv @@
// Double-buffered distance table: one memory per sub-quantizer, both banks in it.
module pqs_table #(
  parameter int unsigned CodebookRows = pqs_pkg::DefCodebookRows,
  parameter int unsigned EntryBits    = pqs_pkg::DefEntryBits
) (
  input  logic                  clk_i,
  input  pqs_pkg::tbl_wr_t      wr_i,
  input  pqs_pkg::tbl_rd_t      rd_i,
  output logic [pqs_pkg::SubQuantizers-1:0][EntryBits-1:0] entries_o,
  output logic [pqs_pkg::SubQuantizers-1:0]                hit_o
);

  localparam int unsigned RowW  = $clog2(CodebookRows);
  localparam int unsigned AddrW = RowW + 1;
  localparam int unsigned Depth = 2 ** AddrW;

  logic row_ok;
  assign row_ok = {1'b0, wr_i.row} < 9'(CodebookRows);

  for (genvar sq = 0; sq < pqs_pkg::SubQuantizers; sq++) begin : g_sq
    localparam int unsigned Lane  = sq % pqs_pkg::Lanes;
    localparam int unsigned Grp   = sq / pqs_pkg::Lanes;
    localparam int unsigned Shift = Lane * EntryBits;
    localparam int unsigned CodeLo = (sq % 8) * pqs_pkg::CodeBits;

    logic [EntryBits-1:0] mem_q [Depth];
    logic [EntryBits-1:0] rdata_q;
    logic                 hit_q;
    logic [EntryBits-1:0] wdata;
    logic [AddrW-1:0]     waddr;
    logic [AddrW-1:0]     raddr;
    logic [7:0]           code;
    logic                 we;

    assign code  = (sq < 8) ? rd_i.codes_low[CodeLo +: pqs_pkg::CodeBits]
                            : rd_i.codes_high[CodeLo +: pqs_pkg::CodeBits];
    assign wdata = EntryBits'(wr_i.words >> Shift);
    assign we    = wr_i.en && row_ok && (wr_i.group == 2'(Grp));
    assign waddr = {wr_i.bank, wr_i.row[RowW-1:0]};
    assign raddr = {rd_i.bank, code[RowW-1:0]};

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem_q[waddr] <= wdata;
      end
      if (rd_i.en) begin
        rdata_q <= mem_q[raddr];
        hit_q   <= {1'b0, code} < 9'(CodebookRows);
      end
    end

    assign entries_o[sq] = rdata_q;
    assign hit_o[sq]     = hit_q;
  end

endmodule
